// File: rtl/div64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// div64_pkg
// Widths and stage count shared by the 64 by 32 divider.
// ----------------------------------------------------------------------------
package div64_pkg;

  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int STAGES     = DIVIDEND_W;

  typedef logic [DIVIDEND_W-1:0] dividend_t;
  typedef logic [DIVISOR_W-1:0]  divisor_t;

  typedef struct packed {
    logic q_neg;
    logic r_neg;
    logic dz;
  } ctrl_t;

endpackage

// File: rtl/divide_64_by_32_signed_unsigned.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divide_64_by_32_signed_unsigned
// Pipelined radix-2 restoring divider, 64-bit dividend by 32-bit divisor,
// signed or unsigned, quotient and remainder.
// ----------------------------------------------------------------------------
//  channel   ports                                        direction
//  in        in_valid/in_ready, in_action/in_dividend/in_divisor   request in
//  out       out_valid/out_ready, out_quotient/out_remainder/
//            out_divide_by_zero                           result out
//
//  An accepted request's magnitudes go into the first register, 64 restoring
//  stages follow (one quotient bit each, a 33-bit compare and subtract),
//  then a sign stage into the output register. A zero divisor holds the
//  dividend in place through the stages. A request enters every cycle; the
//  whole pipeline holds while the output register is full and not taken.
//  Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module divide_64_by_32_signed_unsigned
  import div64_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [DIVIDEND_W-1:0] in_dividend,
  input  logic [DIVISOR_W-1:0]  in_divisor,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIVIDEND_W-1:0] out_quotient,
  output logic [DIVIDEND_W-1:0] out_remainder,
  output logic                  out_divide_by_zero
);

  logic      en;
  logic      v_r    [STAGES+1];
  ctrl_t     c_r    [STAGES+1];
  divisor_t  d_r    [STAGES+1];
  divisor_t  rem_r  [STAGES+1];
  dividend_t qn_r   [STAGES+1];
  divisor_t  rem_nxt[STAGES];
  dividend_t qn_nxt [STAGES];

  logic      n_neg, d_neg;
  dividend_t n_mag;
  divisor_t  d_mag;
  dividend_t rem_mag;

  logic      out_valid_r;
  dividend_t out_q_r, out_r_r;
  logic      out_dz_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    n_neg = in_action && in_dividend[DIVIDEND_W-1];
    d_neg = in_action && in_divisor[DIVISOR_W-1];
    n_mag = n_neg ? (~in_dividend + 1'b1) : in_dividend;
    d_mag = d_neg ? (~in_divisor + 1'b1) : in_divisor;
  end

  always_comb begin
    for (int i = 0; i < STAGES; i++) begin
      logic [DIVISOR_W:0] trial;
      logic               take;
      trial = {rem_r[i], qn_r[i][DIVIDEND_W-1]};
      take  = (trial >= {1'b0, d_r[i]});
      if (c_r[i].dz) begin
        qn_nxt[i]  = qn_r[i];
        rem_nxt[i] = rem_r[i];
      end else begin
        qn_nxt[i]  = {qn_r[i][DIVIDEND_W-2:0], take};
        rem_nxt[i] = take ? DIVISOR_W'(trial - {1'b0, d_r[i]}) : trial[DIVISOR_W-1:0];
      end
    end
  end

  assign rem_mag = c_r[STAGES].dz ? qn_r[STAGES] : DIVIDEND_W'(rem_r[STAGES]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= STAGES; i++) v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 0; i < STAGES; i++) v_r[i+1] <= v_r[i];
      out_valid_r <= v_r[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= '{q_neg: n_neg ^ d_neg, r_neg: n_neg, dz: (in_divisor == '0)};
      d_r[0]   <= d_mag;
      rem_r[0] <= '0;
      qn_r[0]  <= n_mag;
      for (int i = 0; i < STAGES; i++) begin
        c_r[i+1]   <= c_r[i];
        d_r[i+1]   <= d_r[i];
        rem_r[i+1] <= rem_nxt[i];
        qn_r[i+1]  <= qn_nxt[i];
      end
      out_q_r  <= c_r[STAGES].dz ? '0 :
                  c_r[STAGES].q_neg ? (~qn_r[STAGES] + 1'b1) : qn_r[STAGES];
      out_r_r  <= c_r[STAGES].r_neg ? (~rem_mag + 1'b1) : rem_mag;
      out_dz_r <= c_r[STAGES].dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = out_q_r;
  assign out_remainder      = out_r_r;
  assign out_divide_by_zero = out_dz_r;

`ifndef NO_ASSERTIONS
  a_dz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_q_r == '0)
    else $error("zero divisor gave nonzero quotient");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[STAGES] && !c_r[STAGES].dz |-> rem_r[STAGES] < d_r[STAGES])
    else $error("partial remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r[STAGES]) && $stable(qn_r[STAGES]))
    else $error("pipeline moved during stall");
`endif

endmodule
